@@ hdl/tcp_pkg.sv @@
// Shared types and constants for the tuple command token parser.
`timescale 1ns / 1ps
`default_nettype none

package tcp_pkg;

	// Token kinds delivered by the lexer. Kinds above TK_OTHER behave like it.
	localparam logic [4:0] TK_OUT     = 5'd0;
	localparam logic [4:0] TK_IN      = 5'd1;
	localparam logic [4:0] TK_READ    = 5'd2;
	localparam logic [4:0] TK_OPEN    = 5'd3;
	localparam logic [4:0] TK_CLOSE   = 5'd4;
	localparam logic [4:0] TK_COMMA   = 5'd5;
	localparam logic [4:0] TK_COLON   = 5'd6;
	localparam logic [4:0] TK_STRLIT  = 5'd7;
	localparam logic [4:0] TK_INTLIT  = 5'd8;
	localparam logic [4:0] TK_FLTLIT  = 5'd9;
	localparam logic [4:0] TK_STRING  = 5'd10;
	localparam logic [4:0] TK_INTEGER = 5'd11;
	localparam logic [4:0] TK_FLOAT   = 5'd12;
	localparam logic [4:0] TK_LT      = 5'd13;
	localparam logic [4:0] TK_LE      = 5'd14;
	localparam logic [4:0] TK_GT      = 5'd15;
	localparam logic [4:0] TK_GE      = 5'd16;
	localparam logic [4:0] TK_STAR    = 5'd17;
	localparam logic [4:0] TK_EOF     = 5'd18;
	localparam logic [4:0] TK_OTHER   = 5'd19;

	// Result kinds.
	localparam logic [1:0] RK_ELEMENT = 2'd0;
	localparam logic [1:0] RK_DONE    = 2'd1;
	localparam logic [1:0] RK_ERROR   = 2'd2;

	// Command operations.
	localparam logic [1:0] OP_READ   = 2'd0;
	localparam logic [1:0] OP_INPUT  = 2'd1;
	localparam logic [1:0] OP_OUTPUT = 2'd2;

	// Element types.
	localparam logic [1:0] TY_INT = 2'd0;
	localparam logic [1:0] TY_STR = 2'd1;
	localparam logic [1:0] TY_FLT = 2'd2;

	// Conditions.
	localparam logic [2:0] CD_EQ   = 3'd0;
	localparam logic [2:0] CD_WILD = 3'd5;

	// Error codes.
	localparam logic [3:0] ER_BAD_OP      = 4'd0;
	localparam logic [3:0] ER_NO_OPEN     = 4'd1;
	localparam logic [3:0] ER_NO_LITERAL  = 4'd2;
	localparam logic [3:0] ER_NO_TYPE     = 4'd3;
	localparam logic [3:0] ER_NO_COLON    = 4'd4;
	localparam logic [3:0] ER_STR_MISM    = 4'd5;
	localparam logic [3:0] ER_INT_MISM    = 4'd6;
	localparam logic [3:0] ER_FLT_MISM    = 4'd7;
	localparam logic [3:0] ER_FLT_EQUAL   = 4'd8;
	localparam logic [3:0] ER_NO_VALUE    = 4'd9;
	localparam logic [3:0] ER_NO_CLOSE    = 4'd10;
	localparam logic [3:0] ER_NO_EOF      = 4'd11;

	typedef enum logic [3:0] {
		PH_OP    = 4'd0,
		PH_OPEN  = 4'd1,
		PH_LIT   = 4'd2,
		PH_TSEP  = 4'd3,
		PH_TYPE  = 4'd4,
		PH_COLON = 4'd5,
		PH_COND  = 4'd6,
		PH_VAL   = 4'd7,
		PH_PSEP  = 4'd8,
		PH_EOF   = 4'd9,
		PH_SKIP  = 4'd10
	} tcp_phase_t;

	typedef struct packed {
		logic [4:0]  token_kind;
		logic [63:0] token_value;
	} tcp_token_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [1:0]  operation;
		logic [4:0]  element_index;
		logic [1:0]  element_type;
		logic [2:0]  condition;
		logic [63:0] element_value;
		logic [3:0]  error_code;
	} tcp_result_t;

endpackage

`default_nettype wire

@@ hdl/tuple_command_token_parser.sv @@
// Top level of the tuple command token parser.
// Each accepted token goes into the input register, and any result it yields is loaded into the result register.
// Throughput: one token per cycle; the parser state update is a single step per token.
// The only wait comes from a held result: a token that yields a result waits in the
// input register until the result register is free.
// Reset (arst_n low, asynchronous) empties both registers and returns the parser
// to waiting for an operation token with all command state cleared.
`timescale 1ns / 1ps
`default_nettype none

module tuple_command_token_parser #(
	parameter int MAX_ELEMENTS = 20,
	parameter int VALUE_BITS   = 64
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   token_valid,
	output logic                  token_stall,
	input  wire tcp_pkg::tcp_token_t token,
	output logic                  result_valid,
	input  wire                   result_stall,
	output tcp_pkg::tcp_result_t  result
);
	import tcp_pkg::*;

	// Input register. The stored value keeps only the bits that can reach the
	// output, so a narrower value width also trims this register.
	logic                  valid_s1;
	logic [4:0]            kind_s1;
	logic [VALUE_BITS-1:0] value_s1;

	logic                  res_valid;
	tcp_result_t           res;
	logic                  out_free;
	logic                  step;
	logic                  take;

	// The token in the input register is consumed when it produces no result,
	// or when the result register can accept what it produces.
	assign step        = valid_s1 && (!res_valid || out_free);
	assign token_stall = valid_s1 && !step;
	assign take        = token_valid && !token_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1  <= token.token_kind;
			value_s1 <= token.token_value[VALUE_BITS-1:0];
		end
	end

	// Parser state machine and result formation.
	tcp_parse #(
		.MAX_ELEMENTS(MAX_ELEMENTS),
		.VALUE_BITS  (VALUE_BITS)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.kind     (kind_s1),
		.value    (value_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	// Result register; it decouples the parser from downstream stalls.
	tcp_outreg u_outreg (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (step && res_valid),
		.data  (res),
		.stall (result_stall),
		.free  (out_free),
		.valid (result_valid),
		.result(result)
	);

	// The input side only stalls while a token is waiting in the input register.
	a_stall_needs_token: assert property (@(posedge clk) disable iff (!arst_n)
		token_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	// A token whose result is taken must show up at the output next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_valid) |=> result_valid)
		else $error("result lost between parser and result register");

	// Error and completion results never carry a value word.
	a_no_value_on_status: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.result_kind != RK_ELEMENT) |-> (result.element_value == '0))
		else $error("status result carries a value");

endmodule

`default_nettype wire

@@ hdl/tcp_parse.sv @@
// Parser state machine: holds the command state and forms at most one result per token.
`timescale 1ns / 1ps
`default_nettype none

module tcp_parse #(
	parameter int MAX_ELEMENTS = 20,
	parameter int VALUE_BITS   = 64
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    step,
	input  wire [4:0]              kind,
	input  wire [VALUE_BITS-1:0]   value,
	output logic                   res_valid,
	output tcp_pkg::tcp_result_t   res
);
	import tcp_pkg::*;

	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);

	tcp_phase_t       phase_q, phase_d;
	logic [1:0]       op_q, op_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [1:0]       ptype_q, ptype_d;
	logic [2:0]       pcond_q, pcond_d;

	logic             is_cmp;
	logic             tv_star;
	logic             tv_lit;
	logic [1:0]       lit_ty;
	logic [3:0]       lit_err;
	logic [2:0]       eff_cond;
	logic             tv_ok;
	logic [3:0]       tv_err;
	tcp_phase_t       fail_phase;
	logic [63:0]      value_ext;

	assign value_ext  = 64'(value);
	assign is_cmp     = (kind >= TK_LT) && (kind <= TK_GE);
	assign tv_star    = (kind == TK_STAR);
	assign tv_lit     = (kind == TK_STRLIT) || (kind == TK_INTLIT) || (kind == TK_FLTLIT);
	assign fail_phase = (kind == TK_EOF) ? PH_OP : PH_SKIP;
	// A value token straight after the colon compares for equality.
	assign eff_cond   = (phase_q == PH_COND) ? CD_EQ : pcond_q;

	always_comb begin
		lit_ty  = TY_FLT;
		lit_err = ER_FLT_MISM;
		if (kind == TK_STRLIT) begin
			lit_ty  = TY_STR;
			lit_err = ER_STR_MISM;
		end else if (kind == TK_INTLIT) begin
			lit_ty  = TY_INT;
			lit_err = ER_INT_MISM;
		end
	end

	always_comb begin
		tv_ok  = 1'b0;
		tv_err = ER_NO_VALUE;
		if (tv_star) begin
			tv_ok = 1'b1;
		end else if (tv_lit) begin
			if (ptype_q != lit_ty) begin
				tv_err = lit_err;
			end else if (lit_ty == TY_FLT && eff_cond == CD_EQ) begin
				tv_err = ER_FLT_EQUAL;
			end else begin
				tv_ok = 1'b1;
			end
		end
	end

	// Next state.
	always_comb begin
		phase_d = phase_q;
		op_d    = op_q;
		cnt_d   = cnt_q;
		ptype_d = ptype_q;
		pcond_d = pcond_q;
		case (phase_q)
			PH_OP: begin
				phase_d = PH_OPEN;
				if (kind == TK_OUT) begin
					op_d = OP_OUTPUT;
				end else if (kind == TK_IN) begin
					op_d = OP_INPUT;
				end else if (kind == TK_READ) begin
					op_d = OP_READ;
				end else begin
					op_d    = OP_READ;
					phase_d = fail_phase;
				end
			end
			PH_OPEN: begin
				if (kind == TK_OPEN) begin
					cnt_d   = '0;
					phase_d = (op_q == OP_OUTPUT) ? PH_LIT : PH_TYPE;
				end else begin
					phase_d = fail_phase;
				end
			end
			PH_LIT: begin
				if (tv_lit) begin
					cnt_d   = cnt_q + 1'b1;
					phase_d = PH_TSEP;
				end else begin
					phase_d = fail_phase;
				end
			end
			PH_TSEP, PH_PSEP: begin
				if (kind == TK_COMMA && cnt_q < CNT_MAX) begin
					phase_d = (phase_q == PH_TSEP) ? PH_LIT : PH_TYPE;
				end else if (kind == TK_CLOSE) begin
					phase_d = PH_EOF;
				end else begin
					phase_d = fail_phase;
				end
			end
			PH_TYPE: begin
				phase_d = PH_COLON;
				pcond_d = CD_EQ;
				if (kind == TK_STRING) begin
					ptype_d = TY_STR;
				end else if (kind == TK_INTEGER) begin
					ptype_d = TY_INT;
				end else if (kind == TK_FLOAT) begin
					ptype_d = TY_FLT;
				end else begin
					pcond_d = pcond_q;
					phase_d = fail_phase;
				end
			end
			PH_COLON: begin
				phase_d = (kind == TK_COLON) ? PH_COND : fail_phase;
			end
			PH_COND, PH_VAL: begin
				if (phase_q == PH_COND && is_cmp) begin
					pcond_d = 3'(kind - (TK_LT - 5'd1));
					phase_d = PH_VAL;
				end else begin
					if (phase_q == PH_COND) begin
						pcond_d = CD_EQ;
					end
					if (tv_ok) begin
						cnt_d   = cnt_q + 1'b1;
						phase_d = PH_PSEP;
					end else begin
						phase_d = fail_phase;
					end
				end
			end
			PH_EOF: begin
				phase_d = fail_phase;
			end
			default: begin
				phase_d = (kind == TK_EOF) ? PH_OP : PH_SKIP;
			end
		endcase
	end

	// Result for the current token.
	always_comb begin
		res_valid         = 1'b0;
		res               = '0;
		res.operation     = (phase_q == PH_OP) ? OP_READ : op_q;
		res.element_index = 5'(cnt_q);
		case (phase_q)
			PH_OP: begin
				if (kind != TK_OUT && kind != TK_IN && kind != TK_READ) begin
					res_valid      = 1'b1;
					res.result_kind = RK_ERROR;
					res.error_code = ER_BAD_OP;
				end
			end
			PH_OPEN: begin
				if (kind != TK_OPEN) begin
					res_valid      = 1'b1;
					res.result_kind = RK_ERROR;
					res.error_code = ER_NO_OPEN;
				end
			end
			PH_LIT: begin
				res_valid = 1'b1;
				if (tv_lit) begin
					res.result_kind   = RK_ELEMENT;
					res.element_type  = lit_ty;
					res.condition     = CD_EQ;
					res.element_value = value_ext;
				end else begin
					res.result_kind = RK_ERROR;
					res.error_code  = ER_NO_LITERAL;
				end
			end
			PH_TSEP, PH_PSEP: begin
				if (!(kind == TK_COMMA && cnt_q < CNT_MAX) && kind != TK_CLOSE) begin
					res_valid      = 1'b1;
					res.result_kind = RK_ERROR;
					res.error_code = ER_NO_CLOSE;
				end
			end
			PH_TYPE: begin
				if (kind != TK_STRING && kind != TK_INTEGER && kind != TK_FLOAT) begin
					res_valid      = 1'b1;
					res.result_kind = RK_ERROR;
					res.error_code = ER_NO_TYPE;
				end
			end
			PH_COLON: begin
				if (kind != TK_COLON) begin
					res_valid      = 1'b1;
					res.result_kind = RK_ERROR;
					res.error_code = ER_NO_COLON;
				end
			end
			PH_COND, PH_VAL: begin
				if (!(phase_q == PH_COND && is_cmp)) begin
					res_valid = 1'b1;
					if (tv_ok) begin
						res.result_kind  = RK_ELEMENT;
						res.element_type = ptype_q;
						if (tv_star) begin
							res.condition = CD_WILD;
						end else begin
							res.condition     = eff_cond;
							res.element_value = value_ext;
						end
					end else begin
						res.result_kind = RK_ERROR;
						res.error_code  = tv_err;
					end
				end
			end
			PH_EOF: begin
				res_valid = 1'b1;
				if (kind == TK_EOF) begin
					res.result_kind = RK_DONE;
				end else begin
					res.result_kind = RK_ERROR;
					res.error_code  = ER_NO_EOF;
				end
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
		if (res.result_kind != RK_ELEMENT) begin
			res.element_index = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OP;
			op_q    <= OP_READ;
			cnt_q   <= '0;
			ptype_q <= TY_INT;
			pcond_q <= CD_EQ;
		end else if (step) begin
			phase_q <= phase_d;
			op_q    <= op_d;
			cnt_q   <= cnt_d;
			ptype_q <= ptype_d;
			pcond_q <= pcond_d;
		end
	end

endmodule

`default_nettype wire

@@ hdl/tcp_outreg.sv @@
// Result register with valid flag toward the downstream side.
`timescale 1ns / 1ps
`default_nettype none

module tcp_outreg (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    load,
	input  wire tcp_pkg::tcp_result_t data,
	input  wire                    stall,
	output logic                   free,
	output logic                   valid,
	output tcp_pkg::tcp_result_t   result
);
	import tcp_pkg::*;

	logic        valid_q;
	tcp_result_t result_q;

	// The register can take a new result when it is empty or its item leaves now.
	assign free   = !valid_q || !stall;
	assign valid  = valid_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= data;
		end
	end

endmodule

`default_nettype wire
